// ----- hdl/kced_pkg.sv -----
// shared types and constants for the key click event detector
// no dependencies
package kced_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SCAN_PERIOD   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP    = 2'd2;
  localparam logic [1:0] REG_REPEAT        = 2'd3;

  // event flag bit positions
  localparam logic [1:0] EV_SINGLE = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_REPEAT = 2'd3;

  // request function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int unsigned PORT_KEYS = 2;

  // reset values of the configuration registers
  localparam logic [7:0]  SCAN_PERIOD_RST = 8'd20;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [15:0] DOUBLE_GAP_RST  = 16'd200;
  localparam logic [15:0] REPEAT_RST      = 16'd100;

  typedef struct packed {
    logic [7:0]  scan_period;
    logic [15:0] long_press_ticks;
    logic [15:0] double_gap_ticks;
    logic [15:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       scan;
    logic       down;
    logic       clear;
    logic [1:0] clear_event;
  } key_ctrl_t;

endpackage

// ----- hdl/kced_cfg.sv -----
// configuration register file of the key click event detector
// depends on kced_pkg
module kced_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output kced_pkg::cfg_t cfg_o
);

  kced_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kced_pkg::REG_SCAN_PERIOD: cfg_d.scan_period      = cfg_data_i[7:0];
        kced_pkg::REG_LONG_PRESS:  cfg_d.long_press_ticks = cfg_data_i;
        kced_pkg::REG_DOUBLE_GAP:  cfg_d.double_gap_ticks = cfg_data_i;
        kced_pkg::REG_REPEAT:      cfg_d.repeat_ticks     = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_period      <= kced_pkg::SCAN_PERIOD_RST;
      cfg_q.long_press_ticks <= kced_pkg::LONG_PRESS_RST;
      cfg_q.double_gap_ticks <= kced_pkg::DOUBLE_GAP_RST;
      cfg_q.repeat_ticks     <= kced_pkg::REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/kced_key.sv -----
// one key: press classifier state machine, countdown timer and sticky event flags
// depends on kced_pkg
module kced_key (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kced_pkg::key_ctrl_t ctrl_i,
  input  kced_pkg::cfg_t     cfg_i,
  output logic [3:0]         flags_o,
  output logic [3:0]         flags_next_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PRESS  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_DOUBLE = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [15:0] timer_q, timer_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] timer_dec;
  logic        expired;

  // timer counts down first, the scan then sees the decremented value
  assign timer_dec = (timer_q != 16'd0) ? timer_q - 16'd1 : timer_q;
  assign expired   = (timer_dec == 16'd0);

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    flags_d = flags_q;
    if (ctrl_i.tick) begin
      timer_d = timer_dec;
      if (ctrl_i.scan) begin
        unique case (state_q)
          ST_IDLE: begin
            if (ctrl_i.down) begin
              timer_d = cfg_i.long_press_ticks;
              state_d = ST_PRESS;
            end
          end
          ST_PRESS: begin
            if (!ctrl_i.down) begin
              timer_d = cfg_i.double_gap_ticks;
              state_d = ST_WAIT;
            end else if (expired) begin
              timer_d = cfg_i.repeat_ticks;
              flags_d[kced_pkg::EV_LONG] = 1'b1;
              state_d = ST_LONG;
            end
          end
          ST_WAIT: begin
            if (ctrl_i.down) begin
              flags_d[kced_pkg::EV_DOUBLE] = 1'b1;
              state_d = ST_DOUBLE;
            end else if (expired) begin
              flags_d[kced_pkg::EV_SINGLE] = 1'b1;
              state_d = ST_IDLE;
            end
          end
          ST_DOUBLE: begin
            if (!ctrl_i.down) state_d = ST_IDLE;
          end
          ST_LONG: begin
            if (!ctrl_i.down) begin
              state_d = ST_IDLE;
            end else if (expired) begin
              timer_d = cfg_i.repeat_ticks;
              flags_d[kced_pkg::EV_REPEAT] = 1'b1;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
    end else if (ctrl_i.clear) begin
      flags_d = flags_q & ~(4'b0001 << ctrl_i.clear_event);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      timer_q <= 16'd0;
      flags_q <= 4'd0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o      = flags_q;
  assign flags_next_o = flags_d;

endmodule

// ----- hdl/key_click_event_detector.sv -----
// Push-button classifier for KEYS keys. A tick request carries one pressed bit per
// key; every scan_period ticks each key samples its bit and may raise sticky single,
// double, long or repeat flags. A query request tests one flag of one key and clears
// it. Every request gives one result (hit plus the flags of keys 0 and 1). Requests
// pass through an input register, the per-key logic and a result register: one request
// per cycle is taken while the output is not stalled, and a result is held in the result
// register until it is taken. Only keys 0 and 1 see levels and can be queried.
// depends on kced_pkg, kced_cfg, kced_key
module key_click_event_detector #(
  parameter int unsigned KEYS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [1:0]  key_levels_i,
  input  logic        query_key_i,
  input  logic [1:0]  query_event_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [3:0]  flags_key0_o,
  output logic [3:0]  flags_key1_o
);

  kced_pkg::cfg_t cfg;

  logic       in_valid_q, in_valid_d;
  logic       func_q;
  logic [1:0] levels_q;
  logic       qkey_q;
  logic [1:0] qev_q;
  logic       accept, adv, tick, scan;
  logic [7:0] scan_count_q, scan_count_d;
  logic [8:0] scan_next;

  logic [3:0] flags_cur  [KEYS];
  logic [3:0] flags_next [KEYS];
  logic [KEYS-1:0] hit_vec;
  logic       hit_d;
  logic [3:0] flags0_d, flags1_d;

  logic       out_valid_q, out_valid_d;
  logic       hit_q;
  logic [3:0] flags0_q, flags1_q;

  kced_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // request in the input register moves on when the result register is empty or not stalled
  assign adv        = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_valid_d = accept | (in_valid_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      levels_q <= key_levels_i;
      qkey_q   <= query_key_i;
      qev_q    <= query_event_i;
    end
  end

  // scan counter
  assign tick      = adv & (func_q == kced_pkg::FUNC_TICK);
  assign scan_next = {1'b0, scan_count_q} + 9'd1;
  assign scan      = (scan_next >= {1'b0, cfg.scan_period});

  always_comb begin
    scan_count_d = scan_count_q;
    if (tick) scan_count_d = scan ? 8'd0 : scan_next[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_count_q <= 8'd0;
    end else begin
      scan_count_q <= scan_count_d;
    end
  end

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    kced_pkg::key_ctrl_t ctrl;
    logic sel;
    if (k < kced_pkg::PORT_KEYS) begin : g_port
      assign sel       = (qkey_q == 1'(k));
      assign ctrl.down = levels_q[k];
    end else begin : g_noport
      assign sel       = 1'b0;
      assign ctrl.down = 1'b0;
    end
    assign ctrl.tick        = tick;
    assign ctrl.scan        = scan;
    assign ctrl.clear       = adv & (func_q == kced_pkg::FUNC_QUERY) & sel;
    assign ctrl.clear_event = qev_q;
    assign hit_vec[k]       = ctrl.clear & flags_cur[k][qev_q];

    kced_key u_key (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cfg_i        (cfg),
      .flags_o      (flags_cur[k]),
      .flags_next_o (flags_next[k])
    );
  end

  assign hit_d    = |hit_vec;
  assign flags0_d = flags_next[0];

  if (KEYS > 1) begin : g_flags1
    assign flags1_d = flags_next[1];
  end else begin : g_noflags1
    assign flags1_d = 4'd0;
  end

  // result register
  assign out_valid_d = adv | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q    <= hit_d;
      flags0_q <= flags0_d;
      flags1_q <= flags1_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign flags_key0_o = flags0_q;
  assign flags_key1_o = flags1_q;

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_tick_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> !hit_q)
    else $error("tick request produced a hit");

  a_held_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q)
    else $error("stalled request lost from input register");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one key reported a hit");

endmodule
